// File: sv/uart_rx_tx_ring_buffers_defines.svh
// Assertion helpers used by the ring buffer RTL.
`ifndef UART_RX_TX_RING_BUFFERS_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URTRB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ring buffer check failed");

// Consequent must hold in the cycle after the antecedent.
`define URTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ring buffer check failed");

`endif

// File: sv/uartrb_pkg.sv
`default_nettype none

package uartrb_pkg;

	typedef logic [7:0] byte_t;

	// command codes carried by each input transaction
	typedef enum logic [1:0] {
		CMD_LINE_RX  = 2'd0,
		CMD_HOST_TX  = 2'd1,
		CMD_HOST_RX  = 2'd2,
		CMD_TX_READY = 2'd3
	} cmd_t;

	localparam int LEVEL_W = 7;

	// per-cycle ring request
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

	// ring occupancy before this cycle's update
	typedef struct packed {
		logic full;
		logic empty;
	} ring_status_t;

endpackage

`default_nettype wire

// File: sv/uartrb_ram.sv
`default_nettype none

module uartrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/uartrb_ring.sv
`default_nettype none

module uartrb_ring #(
	parameter int RING_DEPTH = 64,
	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	localparam int FILL_W = $clog2(RING_DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire uartrb_pkg::ring_ctl_t    ctl,
	input  wire uartrb_pkg::byte_t        wdata,
	output uartrb_pkg::byte_t             rdata,
	output uartrb_pkg::ring_status_t      status,
	output logic [FILL_W-1:0]             level_next
);

	import uartrb_pkg::*;
	`include "uart_rx_tx_ring_buffers_defines.svh"

	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);

	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign status.full  = (fill_q == FILL_MAX);
	assign status.empty = (fill_q == '0);

	// fill after this cycle; push and pop together leave it unchanged
	always_comb begin
		level_next = fill_q;
		if (ctl.push && !ctl.pop) begin
			level_next = fill_q + 1'b1;
		end else if (ctl.pop && !ctl.push) begin
			level_next = fill_q - 1'b1;
		end
	end

	// pointers wrap at the ring depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			fill_q <= level_next;
		end
	end

	uartrb_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (wr_ptr_q),
		.wdata (wdata),
		.re    (ctl.pop),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	`URTRB_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_MAX)
	`URTRB_ASSERT_SAME(a_no_pop_empty, clk, arst_n, ctl.pop, !status.empty)
	`URTRB_ASSERT_SAME(a_full_push_drops, clk, arst_n, ctl.push && status.full, ctl.pop)
	`URTRB_ASSERT_NEXT(a_push_grows, clk, arst_n, ctl.push && !ctl.pop, fill_q == $past(fill_q) + 1'b1)

endmodule

`default_nettype wire

// File: sv/uart_rx_tx_ring_buffers.sv
// Receive and transmit byte rings between a serial line and a host. Each input
// transaction carries one command (line byte received, host send, host receive,
// transmitter ready) and yields exactly one result. A new command is taken every
// cycle while results are being drained; results come from the result register
// and the registered read port of the ring memories. Both rings are RING_DEPTH
// bytes; their storage is not cleared after reset, only the pointers and fill
// counts are, so the block is ready as soon as reset is released. A full receive
// ring drops its oldest byte on a new line byte; a full transmit ring refuses host
// bytes. In string mode a zero host byte ends the text and is not queued.
`default_nettype none

module uart_rx_tx_ring_buffers #(
	parameter int RING_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  data_byte,
	input  wire logic        string_mode,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             line_tx_valid,
	output logic [7:0]       line_tx_byte,
	output logic             host_byte_valid,
	output logic [7:0]       host_byte,
	output logic             send_accepted,
	output logic             string_end,
	output logic             rx_overwrote,
	output logic [6:0]       rx_level,
	output logic [6:0]       tx_level
);

	import uartrb_pkg::*;

	localparam int FILL_W = $clog2(RING_DEPTH + 1);

	ring_ctl_t         rx_ctl, tx_ctl;
	ring_status_t      rx_stat, tx_stat;
	byte_t             rx_rdata, tx_rdata;
	logic [FILL_W-1:0] rx_level_next, tx_level_next;
	logic [31:0]       rx_level_ext, tx_level_ext;
	logic              accept;
	logic              is_text_end;

	logic              valid_s1;
	logic              line_tx_valid_s1;
	logic              host_byte_valid_s1;
	logic              send_accepted_s1;
	logic              string_end_s1;
	logic              rx_overwrote_s1;
	logic [6:0]        rx_level_s1;
	logic [6:0]        tx_level_s1;

	// take a transaction whenever the result register is free or draining
	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	assign is_text_end = string_mode && (data_byte == '0);

	// ring requests for this transaction
	always_comb begin
		rx_ctl.push = accept && (command == CMD_LINE_RX);
		rx_ctl.pop  = accept && (((command == CMD_LINE_RX) && rx_stat.full) ||
		                         ((command == CMD_HOST_RX) && !rx_stat.empty));
		tx_ctl.push = accept && (command == CMD_HOST_TX) && !tx_stat.full && !is_text_end;
		tx_ctl.pop  = accept && (command == CMD_TX_READY) && !tx_stat.empty;
	end

	uartrb_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_rx_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rx_ctl),
		.wdata      (data_byte),
		.rdata      (rx_rdata),
		.status     (rx_stat),
		.level_next (rx_level_next)
	);

	uartrb_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_tx_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tx_ctl),
		.wdata      (data_byte),
		.rdata      (tx_rdata),
		.status     (tx_stat),
		.level_next (tx_level_next)
	);

	// levels are reported modulo 128
	assign rx_level_ext = 32'(rx_level_next);
	assign tx_level_ext = 32'(tx_level_next);

	// result register; byte payloads come from the ring memories' read registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_tx_valid_s1   <= tx_ctl.pop;
			host_byte_valid_s1 <= (command == CMD_HOST_RX) && !rx_stat.empty;
			send_accepted_s1   <= tx_ctl.push;
			string_end_s1      <= (command == CMD_HOST_TX) && !tx_stat.full && is_text_end;
			rx_overwrote_s1    <= (command == CMD_LINE_RX) && rx_stat.full;
			rx_level_s1        <= rx_level_ext[LEVEL_W-1:0];
			tx_level_s1        <= tx_level_ext[LEVEL_W-1:0];
		end
	end

	assign out_valid       = valid_s1;
	assign line_tx_valid   = line_tx_valid_s1;
	assign line_tx_byte    = line_tx_valid_s1 ? tx_rdata : '0;
	assign host_byte_valid = host_byte_valid_s1;
	assign host_byte       = host_byte_valid_s1 ? rx_rdata : '0;
	assign send_accepted   = send_accepted_s1;
	assign string_end      = string_end_s1;
	assign rx_overwrote    = rx_overwrote_s1;
	assign rx_level        = rx_level_s1;
	assign tx_level        = tx_level_s1;

endmodule

`default_nettype wire

// File: verif/tb_uart_rx_tx_ring_buffers.sv
`default_nettype none

module tb_uart_rx_tx_ring_buffers;
	timeunit 1ns;
	timeprecision 1ps;

	import uartrb_pkg::*;

	localparam int DEPTH = 64;

	// one result transaction, field for field as the ports carry it
	typedef struct packed {
		logic               line_tx_valid;
		byte_t              line_tx_byte;
		logic               host_byte_valid;
		byte_t              host_byte;
		logic               send_accepted;
		logic               string_end;
		logic               rx_overwrote;
		logic [LEVEL_W-1:0] rx_level;
		logic [LEVEL_W-1:0] tx_level;
	} ring_outcome_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic [7:0]         data_byte;
	logic               string_mode;
	logic               out_valid;
	logic               out_stall;
	logic               line_tx_valid;
	logic [7:0]         line_tx_byte;
	logic               host_byte_valid;
	logic [7:0]         host_byte;
	logic               send_accepted;
	logic               string_end;
	logic               rx_overwrote;
	logic [6:0]         rx_level;
	logic [6:0]         tx_level;

	// ring mirror state
	byte_t rx_mem [DEPTH];
	byte_t tx_mem [DEPTH];
	int    rx_rd, rx_wr, rx_count;
	int    tx_rd, tx_wr, tx_count;

	ring_outcome_t outcome_q [$];
	int            err_count;
	bit            no_idle;
	int            rx_hold_len;

	uart_rx_tx_ring_buffers #(
		.RING_DEPTH(DEPTH)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.data_byte      (data_byte),
		.string_mode    (string_mode),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_tx_valid  (line_tx_valid),
		.line_tx_byte   (line_tx_byte),
		.host_byte_valid(host_byte_valid),
		.host_byte      (host_byte),
		.send_accepted  (send_accepted),
		.string_end     (string_end),
		.rx_overwrote   (rx_overwrote),
		.rx_level       (rx_level),
		.tx_level       (tx_level)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic int bump(int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	// advance the mirrored rings by one command, return the result it yields
	function automatic ring_outcome_t advance_rings(cmd_t cmd, byte_t data, logic smode);
		ring_outcome_t res;
		res = '0;
		case (cmd)
			CMD_LINE_RX: begin
				// full ring: overwrite oldest, fill stays at depth
				rx_mem[rx_wr] = data;
				rx_wr = bump(rx_wr);
				if (rx_count >= DEPTH) begin
					rx_rd = bump(rx_rd);
					res.rx_overwrote = 1'b1;
				end else
					rx_count++;
			end
			CMD_HOST_TX: begin
				// room check comes before the string terminator check
				if (tx_count < DEPTH) begin
					if (data == 8'h00 && smode)
						res.string_end = 1'b1;
					else begin
						tx_mem[tx_wr] = data;
						tx_wr = bump(tx_wr);
						tx_count++;
						res.send_accepted = 1'b1;
					end
				end
			end
			CMD_HOST_RX: begin
				if (rx_count > 0) begin
					res.host_byte_valid = 1'b1;
					res.host_byte = rx_mem[rx_rd];
					rx_rd = bump(rx_rd);
					rx_count--;
				end
			end
			default: begin
				if (tx_count > 0) begin
					res.line_tx_valid = 1'b1;
					res.line_tx_byte = tx_mem[tx_rd];
					tx_rd = bump(tx_rd);
					tx_count--;
				end
			end
		endcase
		res.rx_level = LEVEL_W'(rx_count);
		res.tx_level = LEVEL_W'(tx_count);
		return res;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one command transaction, record its expected result when taken
	task automatic send_cmd(cmd_t cmd, byte_t data, logic smode);
		int   gap;
		logic taken;
		gap = (!no_idle && $urandom_range(0, 99) < 40) ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= data;
		string_mode <= smode;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				outcome_q.push_back(advance_rings(cmd, data, smode));
			@(posedge clk);
		end while (!taken);
	endtask

	// sender goes quiet until every expected result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic cmd_t pick_command(int mix);
		int r, t0, t1, t2;
		r = $urandom_range(0, 99);
		case (mix)
			0:       begin t0 = 70; t1 = 80; t2 = 90; end  // receive heavy
			1:       begin t0 = 10; t1 = 80; t2 = 90; end  // send heavy
			2:       begin t0 = 10; t1 = 20; t2 = 60; end  // draining
			default: begin t0 = 25; t1 = 50; t2 = 75; end
		endcase
		if (r < t0) return CMD_LINE_RX;
		if (r < t1) return CMD_HOST_TX;
		if (r < t2) return CMD_HOST_RX;
		return CMD_TX_READY;
	endfunction

	task automatic send_random(int mix);
		cmd_t  cmd;
		byte_t data;
		cmd = pick_command(mix);
		// host text often ends in a zero
		if (cmd == CMD_HOST_TX && $urandom_range(0, 99) < 12)
			data = 8'h00;
		else
			data = byte_t'($urandom_range(0, 255));
		send_cmd(cmd, data, 1'(($urandom_range(0, 1))));
	endtask

	// pops on empty rings, with nonzero unused data bytes and string mode set
	task automatic test_empty_rings();
		send_cmd(CMD_HOST_RX, 8'hFF, 1'b1);
		send_cmd(CMD_TX_READY, 8'hAA, 1'b1);
	endtask

	// byte extremes, string terminator, plain zero byte, every pop
	task automatic test_field_extremes();
		send_cmd(CMD_LINE_RX, 8'h00, 1'b1);
		send_cmd(CMD_LINE_RX, 8'hFF, 1'b0);
		send_cmd(CMD_HOST_TX, 8'hFF, 1'b0);
		send_cmd(CMD_HOST_TX, 8'h00, 1'b0);
		send_cmd(CMD_HOST_TX, 8'h00, 1'b1);
		send_cmd(CMD_HOST_TX, 8'h01, 1'b1);
		repeat (3) send_cmd(CMD_HOST_RX, 8'h00, 1'b0);
		repeat (4) send_cmd(CMD_TX_READY, 8'h55, 1'b0);
	endtask

	// overfill the receive ring, then drain it past empty
	task automatic test_rx_overflow();
		repeat (DEPTH + 6)
			send_cmd(CMD_LINE_RX, byte_t'($urandom_range(0, 255)), 1'(($urandom_range(0, 1))));
		repeat (DEPTH + 2)
			send_cmd(CMD_HOST_RX, byte_t'($urandom_range(0, 255)), 1'b0);
	endtask

	// fill the transmit ring, try sends while full, then drain past empty
	task automatic test_tx_full();
		repeat (DEPTH)
			send_cmd(CMD_HOST_TX, byte_t'($urandom_range(1, 255)), 1'(($urandom_range(0, 1))));
		send_cmd(CMD_HOST_TX, 8'h00, 1'b1);
		send_cmd(CMD_HOST_TX, 8'h5A, 1'b0);
		send_cmd(CMD_HOST_TX, 8'hFF, 1'b1);
		repeat (DEPTH + 2)
			send_cmd(CMD_TX_READY, byte_t'($urandom_range(0, 255)), 1'b0);
	endtask

	// long result hold-off while commands keep coming: input must back up
	task automatic test_result_holdoff();
		rx_hold_len = 300;
		repeat (40) send_random(3);
		wait_drained();
	endtask

	// sender pause with the pipe fully drained in the middle
	task automatic test_sender_pause();
		repeat (20) send_random(3);
		wait_drained();
		repeat (20) send_random(3);
	endtask

	// blocks of biased random traffic, some of them back to back
	task automatic test_random_traffic();
		int done, len;
		done = 0;
		while (done < 500) begin
			len = $urandom_range(20, 90);
			no_idle = ($urandom_range(0, 5) == 0);
			repeat (len) send_random($urandom_range(0, 3));
			done += len;
		end
		no_idle = 1'b0;
	endtask

	// result side: random stall pattern plus requested long hold-offs
	initial begin
		int hold_left, stall_left, free_left;
		hold_left = 0;
		stall_left = 0;
		free_left = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_len != 0) begin
				hold_left = rx_hold_len;
				rx_hold_len = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				out_stall <= 1'b0;
			end else begin
				if (!no_idle && $urandom_range(0, 99) < 35)
					stall_left = gap_len();
				free_left = $urandom_range(0, 12);
				out_stall <= 1'b0;
			end
		end
	end

	// result side: compare each taken result with the oldest expectation
	initial begin
		ring_outcome_t got, want;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				got = '{line_tx_valid, line_tx_byte, host_byte_valid, host_byte,
					send_accepted, string_end, rx_overwrote, rx_level, tx_level};
				if (outcome_q.size() == 0)
					report_mismatch("result transaction with nothing expected");
				else begin
					want = outcome_q.pop_front();
					if (got.line_tx_valid !== want.line_tx_valid)
						report_mismatch($sformatf("line_tx_valid %b exp %b",
							got.line_tx_valid, want.line_tx_valid));
					if (got.line_tx_byte !== want.line_tx_byte)
						report_mismatch($sformatf("line_tx_byte %h exp %h",
							got.line_tx_byte, want.line_tx_byte));
					if (got.host_byte_valid !== want.host_byte_valid)
						report_mismatch($sformatf("host_byte_valid %b exp %b",
							got.host_byte_valid, want.host_byte_valid));
					if (got.host_byte !== want.host_byte)
						report_mismatch($sformatf("host_byte %h exp %h",
							got.host_byte, want.host_byte));
					if (got.send_accepted !== want.send_accepted)
						report_mismatch($sformatf("send_accepted %b exp %b",
							got.send_accepted, want.send_accepted));
					if (got.string_end !== want.string_end)
						report_mismatch($sformatf("string_end %b exp %b",
							got.string_end, want.string_end));
					if (got.rx_overwrote !== want.rx_overwrote)
						report_mismatch($sformatf("rx_overwrote %b exp %b",
							got.rx_overwrote, want.rx_overwrote));
					if (got.rx_level !== want.rx_level)
						report_mismatch($sformatf("rx_level %0d exp %0d",
							got.rx_level, want.rx_level));
					if (got.tx_level !== want.tx_level)
						report_mismatch($sformatf("tx_level %0d exp %0d",
							got.tx_level, want.tx_level));
				end
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		err_count = 0;
		no_idle = 1'b0;
		rx_hold_len = 0;
		rx_rd = 0;
		rx_wr = 0;
		rx_count = 0;
		tx_rd = 0;
		tx_wr = 0;
		tx_count = 0;
		in_valid = 1'b0;
		command = CMD_LINE_RX;
		data_byte = 8'h00;
		string_mode = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_rings();
		test_field_extremes();
		test_rx_overflow();
		test_tx_full();
		test_result_holdoff();
		test_sender_pause();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
